// ===== src/crt2_pkg.sv =====
// shared types and constants for the two-congruence crt solver
package crt2_pkg;

  localparam int unsigned ModBitsDefault = 32;
  localparam int unsigned InBits = 32;
  localparam int unsigned WideBits = 64;

  typedef enum logic [1:0] {
    StatusSolved = 2'd0,
    StatusNoSol = 2'd1,
    StatusInvalid = 2'd2
  } status_e;

  // datapath operations issued by the controller
  typedef enum logic [3:0] {
    OpNone,
    OpLoad,
    OpGcdStep,
    OpDivStart,
    OpDivStep,
    OpInvInit,
    OpInvStep,
    OpMulStart,
    OpMulStep,
    OpCombine,
    OpFinish
  } op_e;

  // divider operand selections
  typedef enum logic [2:0] {
    DivX1G,
    DivX2G,
    DivM1G,
    DivM2G,
    DivInvQ,
    DivT1,
    DivT2
  } dsel_e;

  // multiplier operand selections
  typedef enum logic [2:0] {
    MulY1Inv1,
    MulY2Inv2,
    MulN2T1,
    MulN1T2,
    MulN1N2,
    MulGS,
    MulGProd
  } msel_e;

  // controller states
  typedef enum logic [4:0] {
    SIdle, SCheck, SGcd,
    SDivStart, SDivRun, SDivTake,
    SInvInit, SInvRun,
    SMulStart, SMulRun,
    SCombine, SFinish, SOut
  } state_e;

  typedef struct packed {
    op_e op;
    dsel_e dsel;
    msel_e msel;
    logic inv_sel; // 0: inverse of n2 mod n1, 1: inverse of n1 mod n2
  } cmd_t;

  typedef struct packed {
    logic invalid;
    logic gcd_done;
    logic div_done;
    logic inv_done;
    logic mul_done;
    logic agree;
  } stat_t;

endpackage

// ===== src/crt2_datapath.sv =====
// datapath: gcd, restoring divider, extended euclid and shift-add multiplier
module crt2_datapath import crt2_pkg::*; #(
  parameter int unsigned ModBits = ModBitsDefault
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  cmd_t                cmd_i,
  input  logic [InBits-1:0]   first_residue_i,
  input  logic [InBits-1:0]   first_modulus_i,
  input  logic [InBits-1:0]   second_residue_i,
  input  logic [InBits-1:0]   second_modulus_i,
  output stat_t               stat_o,
  output logic [WideBits-1:0] res_o,
  output logic [WideBits-1:0] mod_o
);

  localparam int unsigned CntBits = 7;

  logic [InBits-1:0] x1_q, m1_q, x2_q, m2_q;
  logic [InBits-1:0] ga_q, gb_q;
  logic [InBits-1:0] g_q, r_q, n1_q, n2_q, y1_q, y2_q, inv1_q, inv2_q;
  logic [WideBits-1:0] t1_q, t2_q, prod_q, s_q, res_q, mod_q;
  logic gcd_phase_q;

  // divider
  logic [WideBits-1:0] dnum_q, dquo_q;
  logic [InBits:0]     drem_q;
  logic [InBits-1:0]   dden_q;
  logic [CntBits-1:0]  dcnt_q;
  logic                dbusy_q;

  // extended euclid
  logic [InBits-1:0]  er0_q, er1_q, en_q;
  logic signed [InBits+1:0] ec0_q, ec1_q;
  logic signed [InBits+1:0] ec1_abs;
  logic               ediv_q, emul_q, ebusy_q;

  // multiplier
  logic [WideBits-1:0] ma_q, mp_q;
  logic [InBits-1:0]   mb_q;
  logic [CntBits-1:0]  mcnt_q;
  logic                mbusy_q;

  logic [InBits-1:0] lim;
  logic bad;
  logic [InBits:0] trial;
  logic [InBits-1:0] d_den;
  logic [WideBits-1:0] d_num;
  logic [WideBits-1:0] m_a;
  logic [InBits-1:0] m_b;
  logic [WideBits-1:0] sum_t;
  logic [WideBits-1:0] gap;

  assign lim = (ModBits >= InBits) ? '1 : InBits'((64'd1 << ModBits) - 64'd1);
  assign bad = (x1_q > lim) || (m1_q > lim) ||
               (x2_q > lim) || (m2_q > lim) ||
               (m1_q == '0) || (m2_q == '0) ||
               (x1_q >= m1_q) ||
               (x2_q >= m2_q);

  always_comb begin
    d_num = '0;
    d_den = g_q;
    unique case (cmd_i.dsel)
      DivX1G: begin d_num = WideBits'(x1_q); d_den = g_q; end
      DivX2G: begin d_num = WideBits'(x2_q); d_den = g_q; end
      DivM1G: begin d_num = WideBits'(m1_q); d_den = g_q; end
      DivM2G: begin d_num = WideBits'(m2_q); d_den = g_q; end
      DivInvQ: begin d_num = WideBits'(er0_q); d_den = er1_q; end
      DivT1: begin d_num = t1_q; d_den = n1_q; end
      DivT2: begin d_num = t2_q; d_den = n2_q; end
      default: begin d_num = '0; d_den = g_q; end
    endcase
  end

  always_comb begin
    m_a = '0;
    m_b = '0;
    unique case (cmd_i.msel)
      MulY1Inv1: begin m_a = WideBits'(y1_q); m_b = inv1_q; end
      MulY2Inv2: begin m_a = WideBits'(y2_q); m_b = inv2_q; end
      MulN2T1: begin m_a = WideBits'(n2_q); m_b = t1_q[InBits-1:0]; end
      MulN1T2: begin m_a = WideBits'(n1_q); m_b = t2_q[InBits-1:0]; end
      MulN1N2: begin m_a = WideBits'(n1_q); m_b = n2_q; end
      MulGS: begin m_a = s_q; m_b = g_q; end
      MulGProd: begin m_a = prod_q; m_b = g_q; end
      default: begin m_a = '0; m_b = '0; end
    endcase
  end

  assign trial = {drem_q[InBits-1:0], dnum_q[WideBits-1]} - {1'b0, dden_q};
  assign gap = prod_q - t2_q;
  assign sum_t = (t1_q >= gap) ? (t1_q - gap) : (t1_q + t2_q);
  assign ec1_abs = ec1_q[InBits+1] ? -ec1_q : ec1_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      dbusy_q <= 1'b0;
      ebusy_q <= 1'b0;
      mbusy_q <= 1'b0;
      gcd_phase_q <= 1'b0;
      ediv_q <= 1'b0;
      emul_q <= 1'b0;
    end else begin
      unique case (cmd_i.op)
        OpLoad: begin
          x1_q <= first_residue_i;
          m1_q <= first_modulus_i;
          x2_q <= second_residue_i;
          m2_q <= second_modulus_i;
          ga_q <= first_modulus_i;
          gb_q <= second_modulus_i;
          gcd_phase_q <= 1'b0;
          dbusy_q <= 1'b0;
          ebusy_q <= 1'b0;
          mbusy_q <= 1'b0;
        end
        OpGcdStep: begin
          // euclidean gcd by repeated remainder: use divider
          if (!dbusy_q && !gcd_phase_q && gb_q != '0) begin
            dnum_q <= WideBits'(ga_q) << (WideBits - InBits);
            dden_q <= gb_q;
            drem_q <= '0;
            dquo_q <= '0;
            dcnt_q <= CntBits'(InBits);
            dbusy_q <= 1'b1;
            gcd_phase_q <= 1'b1;
          end else if (dbusy_q) begin
            drem_q <= trial[InBits] ? {drem_q[InBits-1:0], dnum_q[WideBits-1]} : trial;
            dnum_q <= dnum_q << 1;
            dcnt_q <= dcnt_q - 1'b1;
            if (dcnt_q == CntBits'(1)) dbusy_q <= 1'b0;
          end else if (gcd_phase_q) begin
            ga_q <= gb_q;
            gb_q <= drem_q[InBits-1:0];
            gcd_phase_q <= 1'b0;
          end
          if (gb_q == '0) g_q <= ga_q;
        end
        OpDivStart: begin
          dnum_q <= d_num;
          dden_q <= d_den;
          drem_q <= '0;
          dquo_q <= '0;
          dcnt_q <= CntBits'(WideBits);
          dbusy_q <= 1'b1;
        end
        OpDivStep: begin
          if (dbusy_q) begin
            drem_q <= trial[InBits] ? {drem_q[InBits-1:0], dnum_q[WideBits-1]} : trial;
            dquo_q <= {dquo_q[WideBits-2:0], ~trial[InBits]};
            dnum_q <= dnum_q << 1;
            dcnt_q <= dcnt_q - 1'b1;
            if (dcnt_q == CntBits'(1)) dbusy_q <= 1'b0;
          end
        end
        OpInvInit: begin
          en_q <= cmd_i.inv_sel ? n2_q : n1_q;
          er0_q <= cmd_i.inv_sel ? n2_q : n1_q;
          // a % n with a < 2^32 computed by euclid itself: start r1 = a, loop reduces
          er1_q <= cmd_i.inv_sel ? n1_q : n2_q;
          ec0_q <= '0;
          ec1_q <= (InBits+2)'(1);
          ediv_q <= 1'b0;
          emul_q <= 1'b0;
          ebusy_q <= !((cmd_i.inv_sel ? n2_q : n1_q) <= InBits'(1));
          if ((cmd_i.inv_sel ? n2_q : n1_q) <= InBits'(1)) begin
            if (cmd_i.inv_sel) inv2_q <= '0; else inv1_q <= '0;
          end
        end
        OpInvStep: begin
          if (ebusy_q) begin
            if (er1_q == '0) begin
              ebusy_q <= 1'b0;
              if (cmd_i.inv_sel)
                inv2_q <= ec0_q[InBits+1] ? InBits'(ec0_q + $signed({2'b00, en_q}))
                                          : ec0_q[InBits-1:0];
              else
                inv1_q <= ec0_q[InBits+1] ? InBits'(ec0_q + $signed({2'b00, en_q}))
                                          : ec0_q[InBits-1:0];
            end else if (!ediv_q) begin
              dnum_q <= WideBits'(er0_q) << (WideBits - InBits);
              dden_q <= er1_q;
              drem_q <= '0;
              dquo_q <= '0;
              dcnt_q <= CntBits'(InBits);
              dbusy_q <= 1'b1;
              ediv_q <= 1'b1;
            end else if (dbusy_q) begin
              drem_q <= trial[InBits] ? {drem_q[InBits-1:0], dnum_q[WideBits-1]} : trial;
              dquo_q <= {dquo_q[WideBits-2:0], ~trial[InBits]};
              dnum_q <= dnum_q << 1;
              dcnt_q <= dcnt_q - 1'b1;
              if (dcnt_q == CntBits'(1)) dbusy_q <= 1'b0;
            end else if (!emul_q) begin
              // q * |c1| by shift-add over the quotient bits
              ma_q <= WideBits'(unsigned'(ec1_abs[InBits-1:0]));
              mb_q <= dquo_q[InBits-1:0];
              mp_q <= '0;
              mcnt_q <= CntBits'(InBits);
              mbusy_q <= 1'b1;
              emul_q <= 1'b1;
            end else if (mbusy_q) begin
              if (mb_q[0]) mp_q <= mp_q + ma_q;
              ma_q <= ma_q << 1;
              mb_q <= mb_q >> 1;
              mcnt_q <= mcnt_q - 1'b1;
              if (mcnt_q == CntBits'(1)) mbusy_q <= 1'b0;
            end else begin
              // magnitude product; c1 sign applied here (|c| < n fits)
              er0_q <= er1_q;
              er1_q <= drem_q[InBits-1:0];
              ec0_q <= ec1_q;
              ec1_q <= ec0_q - (ec1_q[InBits+1]
                       ? -$signed({2'b00, mp_q[InBits-1:0]})
                       : $signed({2'b00, mp_q[InBits-1:0]}));
              ediv_q <= 1'b0;
              emul_q <= 1'b0;
            end
          end
        end
        OpMulStart: begin
          ma_q <= m_a;
          mb_q <= m_b;
          mp_q <= '0;
          mcnt_q <= CntBits'(InBits);
          mbusy_q <= 1'b1;
        end
        OpMulStep: begin
          if (mbusy_q) begin
            if (mb_q[0]) mp_q <= mp_q + ma_q;
            ma_q <= ma_q << 1;
            mb_q <= mb_q >> 1;
            mcnt_q <= mcnt_q - 1'b1;
            if (mcnt_q == CntBits'(1)) mbusy_q <= 1'b0;
          end
        end
        default: ;
      endcase
    end
  end

  // results captured by the controller through the mul/div sequence
  always_ff @(posedge clk_i) begin
    if (cmd_i.op == OpNone) begin
      unique case (cmd_i.dsel)
        DivX1G: begin r_q <= drem_q[InBits-1:0]; y1_q <= dquo_q[InBits-1:0]; end
        DivX2G: y2_q <= dquo_q[InBits-1:0];
        DivM1G: n1_q <= dquo_q[InBits-1:0];
        DivM2G: n2_q <= dquo_q[InBits-1:0];
        DivT1: t1_q <= WideBits'(drem_q[InBits-1:0]);
        DivT2: t2_q <= WideBits'(drem_q[InBits-1:0]);
        default: ;
      endcase
    end
    if (cmd_i.op == OpMulStep && !mbusy_q) begin
      unique case (cmd_i.msel)
        MulY1Inv1: t1_q <= mp_q;
        MulY2Inv2: t2_q <= mp_q;
        MulN2T1: t1_q <= mp_q;
        MulN1T2: t2_q <= mp_q;
        MulN1N2: prod_q <= mp_q;
        MulGS: s_q <= mp_q + WideBits'(r_q);
        MulGProd: mod_q <= mp_q;
        default: ;
      endcase
    end
    if (cmd_i.op == OpCombine) s_q <= sum_t;
    if (cmd_i.op == OpFinish) res_q <= s_q;
  end

  assign stat_o.invalid = bad;
  assign stat_o.gcd_done = (gb_q == '0) && !dbusy_q && !gcd_phase_q;
  assign stat_o.div_done = !dbusy_q;
  assign stat_o.inv_done = !ebusy_q;
  assign stat_o.mul_done = !mbusy_q;
  assign stat_o.agree = (drem_q[InBits-1:0] == r_q);
  assign res_o = res_q;
  assign mod_o = mod_q;

endmodule

// ===== src/crt2_ctrl.sv =====
// controller state machine sequencing the datapath operations
module crt2_ctrl import crt2_pkg::*; (
  input  logic    clk_i,
  input  logic    rst_ni,
  input  logic    in_valid_i,
  output logic    in_stall_o,
  output logic    out_valid_o,
  input  logic    out_stall_i,
  input  stat_t   stat_i,
  output cmd_t    cmd_o,
  output status_e status_o
);

  state_e state_q, state_d;
  logic [3:0] step_q, step_d;   // index through the division/multiply plan
  status_e st_q, st_d;

  // plan: div x1/g, div x2/g (agree check), div m1/g, div m2/g,
  // inv1, inv2, mul y1*inv1, div mod n1, mul n2*t1, mul y2*inv2, div mod n2,
  // mul n1*t2, mul n1*n2, combine, mul g*s, mul g*prod
  dsel_e dsel;
  msel_e msel;
  logic inv_sel;

  always_comb begin
    dsel = DivX1G;
    msel = MulY1Inv1;
    inv_sel = 1'b0;
    unique case (step_q)
      4'd0: dsel = DivX1G;
      4'd1: dsel = DivX2G;
      4'd2: dsel = DivM1G;
      4'd3: dsel = DivM2G;
      4'd4: inv_sel = 1'b0;
      4'd5: inv_sel = 1'b1;
      4'd6: msel = MulY1Inv1;
      4'd7: dsel = DivT1;
      4'd8: msel = MulN2T1;
      4'd9: msel = MulY2Inv2;
      4'd10: dsel = DivT2;
      4'd11: msel = MulN1T2;
      4'd12: msel = MulN1N2;
      4'd13: msel = MulGS;
      4'd14: msel = MulGProd;
      default: ;
    endcase
  end

  always_comb begin
    state_d = state_q;
    step_d = step_q;
    st_d = st_q;
    unique case (state_q)
      SIdle: if (in_valid_i) state_d = SCheck;
      SCheck: begin
        if (stat_i.invalid) begin
          st_d = StatusInvalid;
          state_d = SOut;
        end else begin
          st_d = StatusSolved;
          state_d = SGcd;
        end
      end
      SGcd: if (stat_i.gcd_done) begin step_d = 4'd0; state_d = SDivStart; end
      SDivStart: state_d = SDivRun;
      SDivRun: if (stat_i.div_done) state_d = SDivTake;
      SDivTake: begin
        if (step_q == 4'd1 && !stat_i.agree) begin
          st_d = StatusNoSol;
          state_d = SOut;
        end else if (step_q == 4'd3) begin
          step_d = 4'd4;
          state_d = SInvInit;
        end else if (step_q == 4'd7 || step_q == 4'd10) begin
          step_d = step_q + 4'd1;
          state_d = SMulStart;
        end else begin
          step_d = step_q + 4'd1;
          state_d = SDivStart;
        end
      end
      SInvInit: state_d = SInvRun;
      SInvRun: if (stat_i.inv_done) begin
        step_d = step_q + 4'd1;
        state_d = (step_q == 4'd4) ? SInvInit : SMulStart;
      end
      SMulStart: state_d = SMulRun;
      SMulRun: if (stat_i.mul_done) begin
        step_d = step_q + 4'd1;
        priority case (step_q)
          4'd6, 4'd9: state_d = SDivStart;
          4'd12: state_d = SCombine;
          4'd14: state_d = SFinish;
          default: state_d = SMulStart;
        endcase
      end
      SCombine: state_d = SMulStart;
      SFinish: state_d = SOut;
      SOut: if (!out_stall_i) state_d = SIdle;
      default: state_d = SIdle;
    endcase
  end

  always_comb begin
    cmd_o.dsel = dsel;
    cmd_o.msel = msel;
    cmd_o.inv_sel = inv_sel;
    cmd_o.op = OpNone;
    unique case (state_q)
      SIdle: cmd_o.op = in_valid_i ? OpLoad : OpNone;
      SGcd: cmd_o.op = OpGcdStep;
      SDivStart: cmd_o.op = OpDivStart;
      SDivRun: cmd_o.op = OpDivStep;
      SInvInit: cmd_o.op = OpInvInit;
      SInvRun: cmd_o.op = OpInvStep;
      SMulStart: cmd_o.op = OpMulStart;
      SMulRun: cmd_o.op = OpMulStep;
      SCombine: cmd_o.op = OpCombine;
      SFinish: cmd_o.op = OpFinish;
      default: cmd_o.op = OpNone;
    endcase
    // divider results are latched in the take state
    if (state_q == SDivTake) cmd_o.op = OpNone;
    else if (cmd_o.op == OpNone) cmd_o.dsel = DivInvQ;
  end

  assign in_stall_o = (state_q != SIdle);
  assign out_valid_o = (state_q == SOut);
  assign status_o = st_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= SIdle;
      step_q <= '0;
      st_q <= StatusSolved;
    end else begin
      state_q <= state_d;
      step_q <= step_d;
      st_q <= st_d;
    end
  end

endmodule

// ===== src/crt_two_congruence_solver_core.sv =====
// Two-congruence CRT solver: one item at a time, a result per input item.
// An item costs six divisions, seven shift-add multiplies and control steps,
// plus one division per gcd remainder step and one division and one multiply
// per extended-Euclid step, for both inverses. Invalid inputs go from the
// check state straight to the output; unsolvable ones answer after the gcd
// and two divisions. The next item is taken once the result is sent.
module crt_two_congruence_solver_core import crt2_pkg::*; #(
  parameter int unsigned MOD_BITS = ModBitsDefault
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                in_valid_i,
  output logic                in_stall_o,
  input  logic [InBits-1:0]   first_residue_i,
  input  logic [InBits-1:0]   first_modulus_i,
  input  logic [InBits-1:0]   second_residue_i,
  input  logic [InBits-1:0]   second_modulus_i,
  output logic                out_valid_o,
  input  logic                out_stall_i,
  output logic [1:0]          status_o,
  output logic [WideBits-1:0] solution_residue_o,
  output logic [WideBits-1:0] solution_modulus_o
);

  cmd_t cmd;
  stat_t stat;
  status_e st;
  logic [WideBits-1:0] res, md;

  crt2_ctrl u_ctrl (
    .clk_i, .rst_ni, .in_valid_i, .in_stall_o, .out_valid_o, .out_stall_i,
    .stat_i(stat), .cmd_o(cmd), .status_o(st)
  );

  crt2_datapath #(.ModBits(MOD_BITS)) u_dp (
    .clk_i, .rst_ni, .cmd_i(cmd),
    .first_residue_i, .first_modulus_i, .second_residue_i, .second_modulus_i,
    .stat_o(stat), .res_o(res), .mod_o(md)
  );

  assign status_o = st;
  assign solution_residue_o = (st == StatusSolved) ? res : '0;
  assign solution_modulus_o = (st == StatusSolved) ? md : '0;

endmodule
